### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file mfp_checker.sv.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the property holds in the following cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hw/rtl/mfp_pkg.sv
// Types, codes and decode helpers for the market feed message parser.
// Standalone package; used by the parser stage, the top level and the checker.
package mfp_pkg;

    localparam int SYMBOL_BYTES = 8;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_VALUE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_LENGTH = 1'd1;

    localparam logic [7:0] TYPE_ADD        = 8'h41; // 'A'
    localparam logic [7:0] TYPE_ADD_PART   = 8'h46; // 'F'
    localparam logic [7:0] TYPE_EXEC       = 8'h45; // 'E'
    localparam logic [7:0] TYPE_EXEC_PRICE = 8'h43; // 'C'
    localparam logic [7:0] TYPE_CANCEL     = 8'h58; // 'X'
    localparam logic [7:0] TYPE_DELETE     = 8'h44; // 'D'
    localparam logic [7:0] TYPE_REPLACE    = 8'h55; // 'U'

    localparam logic [2:0] KIND_ADD        = 3'd0;
    localparam logic [2:0] KIND_ADD_PART   = 3'd1;
    localparam logic [2:0] KIND_EXEC       = 3'd2;
    localparam logic [2:0] KIND_EXEC_PRICE = 3'd3;
    localparam logic [2:0] KIND_CANCEL     = 3'd4;
    localparam logic [2:0] KIND_DELETE     = 3'd5;
    localparam logic [2:0] KIND_REPLACE    = 3'd6;
    localparam logic [2:0] KIND_NONE       = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_range;
    } feed_item_t;

    typedef struct packed {
        logic [2:0]  msg_kind;
        logic [63:0] timestamp;
        logic [63:0] order_ref;
        logic [7:0]  side_code;
        logic [31:0] share_count;
        logic [31:0] executed_shares;
        logic [63:0] match_id;
        logic [7:0]  printable_flag;
        logic [31:0] price_units;
        logic [63:0] symbol_bytes;
        logic [31:0] parsed_total;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] prefix_value;
        logic [3:0]  filter_length;
    } cfg_t;

    function automatic logic [2:0] kind_of(input logic [7:0] t);
        logic [2:0] k;
        case (t)
            TYPE_ADD:        k = KIND_ADD;
            TYPE_ADD_PART:   k = KIND_ADD_PART;
            TYPE_EXEC:       k = KIND_EXEC;
            TYPE_EXEC_PRICE: k = KIND_EXEC_PRICE;
            TYPE_CANCEL:     k = KIND_CANCEL;
            TYPE_DELETE:     k = KIND_DELETE;
            TYPE_REPLACE:    k = KIND_REPLACE;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Minimum body length of each layout.
    function automatic logic [15:0] layout_min(input logic [2:0] k);
        logic [15:0] m;
        case (k)
            KIND_ADD, KIND_ADD_PART, KIND_EXEC_PRICE: m = 16'd34;
            KIND_EXEC:                                m = 16'd29;
            KIND_CANCEL:                              m = 16'd21;
            KIND_DELETE, KIND_REPLACE:                m = 16'd17;
            default:                                  m = 16'hFFFF;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/mfp_frame_parser.sv
// Framing, field capture and result assembly, one stream byte per cycle while advance is high.
// Depends on mfp_pkg for item types, kind codes and layout decode.
module mfp_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  mfp_pkg::feed_item_t item,
    input  mfp_pkg::cfg_t       cfg,
    output logic               emit,
    output mfp_pkg::msg_item_t  result
);

    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic [1:0]  phase_reg,  phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] pos_reg,    pos_next;
    logic [2:0]  kind_reg,   kind_next;
    logic [7:0]  side_reg,   side_next;
    logic [63:0] ts_reg,     ts_next;
    logic [63:0] order_reg,  order_next;
    logic [31:0] qty_reg,    qty_next;
    logic [63:0] match_reg,  match_next;
    logic [63:0] sym_reg,    sym_next;
    logic [31:0] price_reg,  price_next;
    logic [31:0] count_reg,  count_next;

    logic [15:0] pos_inc;
    logic [7:0]  b;
    logic        adds;
    logic        execs;
    logic [63:0] sym_cmp;
    logic [31:0] count_inc;

    function automatic logic filter_pass(input logic [63:0] sym, input logic [63:0] filt,
                                         input logic [3:0] len);
        logic [3:0] n;
        logic       ok;
        n  = (len > 4'(mfp_pkg::SYMBOL_BYTES)) ? 4'(mfp_pkg::SYMBOL_BYTES) : len;
        ok = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n && sym[63-8*i -: 8] != filt[63-8*i -: 8])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        kind_next   = kind_reg;
        side_next   = side_reg;
        ts_next     = ts_reg;
        order_next  = order_reg;
        qty_next    = qty_reg;
        match_next  = match_reg;
        sym_next    = sym_reg;
        price_next  = price_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        result      = '0;
        b           = item.data_byte;
        pos_inc     = pos_reg + 16'd1;
        count_inc   = count_reg + 32'd1;
        adds        = 1'b0;
        execs       = 1'b0;
        sym_cmp     = '0;

        case (phase_reg)
            PH_LEN_LO:
            begin
                length_next = {length_reg[7:0], b};
                pos_next    = '0;
                phase_next  = ({length_reg[7:0], b} == 16'd0) ? PH_LEN_HI : PH_BODY;
            end
            PH_BODY:
            begin
                if (pos_reg == 16'd0)
                begin
                    kind_next  = mfp_pkg::kind_of(b);
                    side_next  = '0;
                    ts_next    = '0;
                    order_next = '0;
                    qty_next   = '0;
                    match_next = '0;
                    sym_next   = '0;
                    price_next = '0;
                end
                else if (pos_reg inside {[16'd1:16'd8]})
                begin
                    ts_next = {ts_reg[55:0], b};
                end
                else if (pos_reg inside {[16'd9:16'd16]})
                begin
                    order_next = {order_reg[55:0], b};
                end
                else if (kind_reg == mfp_pkg::KIND_ADD || kind_reg == mfp_pkg::KIND_ADD_PART)
                begin
                    if (pos_reg == 16'd17)
                        side_next = b;
                    else if (pos_reg <= 16'd21)
                        qty_next = {qty_reg[23:0], b};
                    else if (pos_reg <= 16'd29)
                        sym_next = {sym_reg[55:0], b};
                    else if (pos_reg <= 16'd33)
                        price_next = {price_reg[23:0], b};
                end
                else if (kind_reg == mfp_pkg::KIND_EXEC || kind_reg == mfp_pkg::KIND_EXEC_PRICE)
                begin
                    if (pos_reg <= 16'd20)
                        qty_next = {qty_reg[23:0], b};
                    else if (pos_reg <= 16'd28)
                        match_next = {match_reg[55:0], b};
                    else if (kind_reg == mfp_pkg::KIND_EXEC_PRICE && pos_reg == 16'd29)
                        side_next = b;
                    else if (kind_reg == mfp_pkg::KIND_EXEC_PRICE && pos_reg <= 16'd33)
                        price_next = {price_reg[23:0], b};
                end
                else if (kind_reg == mfp_pkg::KIND_CANCEL)
                begin
                    if (pos_reg <= 16'd20)
                        qty_next = {qty_reg[23:0], b};
                end

                pos_next = pos_inc;
                if (pos_inc >= length_reg)
                begin
                    phase_next = PH_LEN_HI;
                    if (kind_next != mfp_pkg::KIND_NONE
                        && length_reg >= mfp_pkg::layout_min(kind_next))
                    begin
                        count_next = count_inc;
                        adds  = (kind_next == mfp_pkg::KIND_ADD
                                 || kind_next == mfp_pkg::KIND_ADD_PART);
                        execs = (kind_next == mfp_pkg::KIND_EXEC
                                 || kind_next == mfp_pkg::KIND_EXEC_PRICE);
                        sym_cmp = adds ? sym_next : 64'd0;
                        emit = filter_pass(sym_cmp, cfg.prefix_value, cfg.filter_length);
                        result.msg_kind        = kind_next;
                        result.timestamp       = ts_next;
                        result.order_ref       = order_next;
                        result.side_code       = adds ? side_next : 8'd0;
                        result.share_count     = (adds || kind_next == mfp_pkg::KIND_CANCEL)
                                                 ? qty_next : 32'd0;
                        result.executed_shares = execs ? qty_next : 32'd0;
                        result.match_id        = execs ? match_next : 64'd0;
                        result.printable_flag  = (kind_next == mfp_pkg::KIND_EXEC_PRICE)
                                                 ? side_next : 8'd0;
                        result.price_units     = (adds || kind_next == mfp_pkg::KIND_EXEC_PRICE)
                                                 ? price_next : 32'd0;
                        result.symbol_bytes    = sym_cmp;
                        result.parsed_total    = count_inc;
                    end
                end
            end
            default:
            begin
                length_next = {8'h00, b};
                phase_next  = PH_LEN_LO;
            end
        endcase

        if (item.last_in_range)
        begin
            phase_next  = PH_LEN_HI;
            length_next = '0;
            pos_next    = '0;
            kind_next   = mfp_pkg::KIND_NONE;
            side_next   = '0;
            ts_next     = '0;
            order_next  = '0;
            qty_next    = '0;
            match_next  = '0;
            sym_next    = '0;
            price_next  = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN_HI;
            length_reg <= '0;
            pos_reg    <= '0;
            kind_reg   <= mfp_pkg::KIND_NONE;
            side_reg   <= '0;
            ts_reg     <= '0;
            order_reg  <= '0;
            qty_reg    <= '0;
            match_reg  <= '0;
            sym_reg    <= '0;
            price_reg  <= '0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            kind_reg   <= kind_next;
            side_reg   <= side_next;
            ts_reg     <= ts_next;
            order_reg  <= order_next;
            qty_reg    <= qty_next;
            match_reg  <= match_next;
            sym_reg    <= sym_next;
            price_reg  <= price_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/market_feed_message_parser.sv
// Top level of the market feed message parser: input register, parser stage,
// result register and configuration registers. Depends on mfp_pkg, mfp_frame_parser.
//
// Usage:
//   feed channel (feed_valid/feed_ready/feed): one stream byte per transaction,
//     with last_in_range marking the final byte of a range.
//   msg channel (msg_valid/msg_ready/msg): one transaction per recognized
//     message that passes the symbol prefix filter, presented on the cycle
//     after its last body byte is parsed.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//     index 0 prefix_value, index 1 filter_length (low 4 bits).
// Result path: the final body byte of a message is parsed from the input
//   register, then the result is loaded into the result register, which
//   drives msg_valid.
// Throughput: one byte per cycle, set by the parser stage, while msg is not stalled.
// Reset: framing waits for a length high byte, count and filter cleared.
// Stall: while msg is held, one byte waits in the input register and
//   feed_ready drops; no data is lost.
module market_feed_message_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                feed_valid,
    output logic                                feed_ready,
    input  mfp_pkg::feed_item_t                 feed,
    output logic                                msg_valid,
    input  logic                                msg_ready,
    output mfp_pkg::msg_item_t                  msg,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [63:0]                         cfg_data
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    mfp_pkg::feed_item_t s1_item_reg;
    logic                res_valid_reg;
    logic                res_valid_next;
    mfp_pkg::msg_item_t  res_reg;
    mfp_pkg::cfg_t       cfg_reg;
    logic                advance;
    logic                emit;
    mfp_pkg::msg_item_t  result;

    assign advance    = s1_valid_reg && (!res_valid_reg || msg_ready);
    assign feed_ready = !s1_valid_reg || advance;
    assign cfg_ready  = 1'b1;
    assign msg_valid  = res_valid_reg;
    assign msg        = res_reg;

    assign s1_valid_next  = (feed_valid && feed_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign res_valid_next = advance ? emit : (msg_ready ? 1'b0 : res_valid_reg);

    mfp_frame_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mfp_pkg::CFG_PREFIX_VALUE:  cfg_reg.prefix_value  <= cfg_data;
                    mfp_pkg::CFG_FILTER_LENGTH: cfg_reg.filter_length <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_valid && feed_ready)
        begin
            s1_item_reg <= feed;
        end
        if (advance && emit)
        begin
            res_reg <= result;
        end
    end

endmodule

### hw/rtl/mfp_checker.sv
// Port-level checks for market_feed_message_parser, attached by bind.
// Depends on mfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            feed_valid,
    input logic                            feed_ready,
    input mfp_pkg::feed_item_t             feed,
    input logic                            msg_valid,
    input logic                            msg_ready,
    input mfp_pkg::msg_item_t              msg,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [mfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [63:0]                     cfg_data
);

    logic unused_ok;
    assign unused_ok = feed_valid ^ (^feed) ^ cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);

    `ASSERT_NEXT(a_msg_hold, msg_valid && !msg_ready, msg_valid && $stable(msg), "msg changed while stalled")
    `ASSERT_CLK(a_feed_backpressure, !feed_ready -> (msg_valid && !msg_ready), "feed stalled without msg stall")
    `ASSERT_CLK(a_exec_zero, !(msg_valid && msg.msg_kind == mfp_pkg::KIND_EXEC) || (msg.side_code == 8'd0 && msg.printable_flag == 8'd0 && msg.price_units == 32'd0 && msg.symbol_bytes == 64'd0 && msg.share_count == 32'd0), "executed fields not zero")
    `ASSERT_CLK(a_short_zero, !(msg_valid && (msg.msg_kind == mfp_pkg::KIND_DELETE || msg.msg_kind == mfp_pkg::KIND_REPLACE)) || (msg.share_count == 32'd0 && msg.executed_shares == 32'd0 && msg.match_id == 64'd0 && msg.price_units == 32'd0 && msg.symbol_bytes == 64'd0), "delete/replace fields not zero")

endmodule

bind market_feed_message_parser mfp_checker u_mfp_checker (.*);
